### rtl/ptcr_pkg.sv
package ptcr_pkg;

    // Default sizes
    localparam int DEF_RING_DEPTH = 128;
    localparam int DEF_MAX_READ   = 64;

    // Field widths
    localparam int TIME_W  = 64;
    localparam int COUNT_W = 7;
    localparam int MAXS_W  = 7;
    localparam int PER_W   = 32;

    // Register map (index = paddr[3:2])
    localparam logic [1:0] REG_CAPTURE_EN = 2'd0;
    localparam logic [1:0] REG_MAX_STORED = 2'd1;
    localparam logic [1:0] REG_PERIOD     = 2'd2;

    // Reset values
    localparam logic [MAXS_W-1:0] RST_MAX_STORED = 7'd127;
    localparam logic [PER_W-1:0]  RST_PERIOD     = 32'd3333333;

    // Item kinds and status codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;
    localparam logic STS_OK          = 1'b0;
    localparam logic STS_NOT_STARTED = 1'b1;

endpackage

### rtl/periodic_timestamp_capture_ring_core.sv
// Channel    Direction  Handshake          Payload
// s_*        in         s_tvalid/s_tready  tuser: action; tdata: current_time, read_count
// m_*        out        m_tvalid/m_tready  tuser: status, has_data; tdata: timestamp,
//                                          delivered; tlast: last
// APB        in         psel/penable       capture_enable, max_stored, period_ticks
//
// A tick with capture enabled updates the counter and, on a capture, makes one write to the ring memory.
// A read enters a loop that pops entries through the single read port of the ring memory,
// blocking new items; a refused, empty or zero-count read gives a single result directly.
// Results pass a registered memory read stage and an output register; a stalled output
// holds the read loop and blocks new items once both stages are full.
// Reset is synchronous and empties the ring; the ring memory itself is not cleared.
module periodic_timestamp_capture_ring_core #(
    parameter int RING_DEPTH = ptcr_pkg::DEF_RING_DEPTH,
    parameter int MAX_READ   = ptcr_pkg::DEF_MAX_READ
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] current_time, [70:64] read_count, [71] zero
    input  logic        s_tuser,   // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] timestamp, [70:64] delivered, [71] zero
    output logic [1:0]  m_tuser,   // [0] status, [1] has_data
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ptcr_pkg::*;

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LW = $clog2(RING_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    // configuration
    logic              r_cap_en;
    logic [MAXS_W-1:0] r_max_stored;
    logic [PER_W-1:0]  r_period;

    // ring control
    logic [PW-1:0]    r_rp, r_wp;
    logic [PER_W-1:0] r_tick;
    logic             r_state;
    logic [COUNT_W-1:0] r_want, r_cnt;

    // memory and read stage
    logic [TIME_W-1:0] mem [RING_DEPTH];
    logic [TIME_W-1:0] r_rd_data;
    logic               r_p_valid, r_p_status, r_p_hd, r_p_last;
    logic [COUNT_W-1:0] r_p_dlv;

    // output register
    logic               r_o_valid, r_o_status, r_o_hd, r_o_last;
    logic [TIME_W-1:0]  r_o_ts;
    logic [COUNT_W-1:0] r_o_dlv;

    logic [12:0]  len_w;
    logic [LW-1:0] ring_len;
    assign len_w    = 13'(r_max_stored) + 13'd1;
    assign ring_len = (len_w > 13'(RING_DEPTH)) ? LW'(RING_DEPTH) : LW'(len_w);

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] pos,
                                              input logic [LW-1:0] len);
        logic [LW-1:0] nxt;
        nxt = LW'(pos) + LW'(1);
        return (nxt >= len) ? PW'(0) : nxt[PW-1:0];
    endfunction

    // input fields
    logic               in_action;
    logic [TIME_W-1:0]  in_time;
    logic [COUNT_W-1:0] in_count, in_want;
    assign in_action = s_tuser;
    assign in_time   = s_tdata[63:0];
    assign in_count  = s_tdata[70:64];
    assign in_want   = (in_count > COUNT_W'(MAX_READ)) ? COUNT_W'(MAX_READ) : in_count;

    // handshakes
    logic o_free, p_move, p_free, s_acc, cfg_wr;
    assign o_free = !r_o_valid || m_tready;
    assign p_move = r_p_valid && o_free;
    assign p_free = !r_p_valid || o_free;
    assign s_tready = (r_state == ST_IDLE) && p_free;
    assign s_acc  = s_tvalid && s_tready;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // tick path
    logic [PER_W:0] cnt_inc;
    logic           tick_go, capture;
    logic [PW-1:0]  wp_nxt;
    assign cnt_inc = {1'b0, r_tick} + (PER_W+1)'(1);
    assign tick_go = s_acc && (in_action == ACT_TICK) && r_cap_en;
    assign capture = tick_go && (cnt_inc >= {1'b0, r_period});
    assign wp_nxt  = advance(r_wp, ring_len);

    // read path
    logic          rd_acc, rd_single, rd_enter, issue, iss_last;
    logic [PW-1:0] rp_nxt;
    logic [COUNT_W-1:0] cnt_nxt;
    assign rd_acc    = s_acc && (in_action == ACT_READ);
    assign rd_enter  = rd_acc && r_cap_en && (r_rp != r_wp) && (in_want != '0);
    assign rd_single = rd_acc && !rd_enter;
    assign issue     = (r_state == ST_READ) && p_free;
    assign rp_nxt    = advance(r_rp, ring_len);
    assign cnt_nxt   = r_cnt + COUNT_W'(1);
    assign iss_last  = (cnt_nxt == r_want) || (rp_nxt == r_wp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_en     <= 1'b0;
            r_max_stored <= RST_MAX_STORED;
            r_period     <= RST_PERIOD;
            r_rp         <= '0;
            r_wp         <= '0;
            r_tick       <= '0;
            r_state      <= ST_IDLE;
        end else if (cfg_wr &&
                     (paddr[3:2] inside {REG_CAPTURE_EN, REG_MAX_STORED, REG_PERIOD})) begin
            case (paddr[3:2])
                REG_CAPTURE_EN: r_cap_en     <= pwdata[0];
                REG_MAX_STORED: r_max_stored <= pwdata[MAXS_W-1:0];
                REG_PERIOD:     r_period     <= pwdata;
                default:        r_cap_en     <= r_cap_en;
            endcase
            // any write to a mapped register empties the ring
            r_rp    <= '0;
            r_wp    <= '0;
            r_tick  <= '0;
            r_state <= ST_IDLE;
        end else begin
            if (tick_go) begin
                r_tick <= capture ? '0 : cnt_inc[PER_W-1:0];
            end
            if (capture) begin
                r_wp <= wp_nxt;
                // drop oldest when full
                if (wp_nxt == r_rp) begin
                    r_rp <= rp_nxt;
                end
            end
            if (rd_enter) begin
                r_state <= ST_READ;
            end
            if (issue) begin
                r_rp <= rp_nxt;
                if (iss_last) begin
                    r_state <= ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_enter) begin
            r_want <= in_want;
            r_cnt  <= '0;
        end else if (issue) begin
            r_cnt <= cnt_nxt;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (capture) begin
            mem[r_wp] <= in_time;
        end
        if (issue) begin
            r_rd_data <= mem[r_rp];
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (issue || rd_single) begin
            r_p_valid <= 1'b1;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_p_status <= STS_OK;
            r_p_hd     <= 1'b1;
            r_p_last   <= iss_last;
            r_p_dlv    <= cnt_nxt;
        end else if (rd_single) begin
            r_p_status <= r_cap_en ? STS_OK : STS_NOT_STARTED;
            r_p_hd     <= 1'b0;
            r_p_last   <= 1'b1;
            r_p_dlv    <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_status <= r_p_status;
            r_o_hd     <= r_p_hd;
            r_o_last   <= r_p_last;
            r_o_dlv    <= r_p_dlv;
            r_o_ts     <= r_p_hd ? r_rd_data : '0;
        end
    end

    assign m_tvalid = r_o_valid;
    assign m_tdata  = {1'b0, r_o_dlv, r_o_ts};
    assign m_tuser  = {r_o_hd, r_o_status};
    assign m_tlast  = r_o_last;

    always_comb begin
        case (paddr[3:2])
            REG_CAPTURE_EN: prdata = {31'b0, r_cap_en};
            REG_MAX_STORED: prdata = {{(32-MAXS_W){1'b0}}, r_max_stored};
            REG_PERIOD:     prdata = r_period;
            default:        prdata = '0;
        endcase
    end

    a_read_needs_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> r_cap_en)
        else $error("read loop running while capture is off");

    a_ptr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LW'(r_rp) < ring_len) && (LW'(r_wp) < ring_len))
        else $error("ring pointer outside ring length");

    a_issue_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (r_rp != r_wp))
        else $error("pop issued from empty ring");

    a_refused_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status) |-> (r_o_last && !r_o_hd && (r_o_dlv == '0)))
        else $error("not-started result is not a lone empty result");

    a_no_tick_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !capture)
        else $error("capture write during read loop");

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptcr_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic        sts;
        logic        has_data;
        logic [63:0] stamp;
        logic        is_last;
        logic [6:0]  count;
    } t_pop_result;

    class capture_ring_scoreboard;
        logic [63:0] ring_mem [DEF_RING_DEPTH];
        int unsigned rd_ptr;
        int unsigned wr_ptr;
        logic [31:0] tick_cnt;
        logic        cap_en;
        logic [6:0]  max_kept;
        logic [31:0] period;
        t_pop_result pending_pops[$];
        int          errors;

        function new();
            cap_en   = 1'b0;
            max_kept = RST_MAX_STORED;
            period   = RST_PERIOD;
            rd_ptr   = 0;
            wr_ptr   = 0;
            tick_cnt = '0;
            errors   = 0;
        endfunction

        function int unsigned next_slot(int unsigned pos);
            int unsigned len;
            len = max_kept + 1;
            if (len > DEF_RING_DEPTH) len = DEF_RING_DEPTH;
            return (pos + 1 >= len) ? 0 : pos + 1;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_CAPTURE_EN: cap_en = val[0];
                REG_MAX_STORED: max_kept = val[6:0];
                REG_PERIOD:     period = val;
                default:        return;
            endcase
            // any register write empties the ring
            rd_ptr   = 0;
            wr_ptr   = 0;
            tick_cnt = '0;
        endfunction

        function void note_item(logic act, logic [63:0] now_ns, logic [6:0] want_in);
            t_pop_result r;
            logic [32:0] cnt;
            int unsigned want;
            int unsigned n;
            int unsigned nxt;
            if (act == ACT_TICK) begin
                if (cap_en) begin
                    cnt = tick_cnt + 33'd1;
                    if (cnt >= {1'b0, period}) begin
                        nxt = next_slot(wr_ptr);
                        // drop the oldest entry when full
                        if (nxt == rd_ptr) rd_ptr = next_slot(rd_ptr);
                        ring_mem[wr_ptr] = now_ns;
                        wr_ptr = nxt;
                        tick_cnt = '0;
                    end else begin
                        tick_cnt = cnt[31:0];
                    end
                end
                return;
            end
            r.has_data = 1'b0;
            r.stamp    = '0;
            r.is_last  = 1'b1;
            r.count    = '0;
            if (!cap_en) begin
                r.sts = STS_NOT_STARTED;
                pending_pops.push_back(r);
                return;
            end
            r.sts = STS_OK;
            want = (want_in > DEF_MAX_READ) ? DEF_MAX_READ : want_in;
            n = 0;
            while (n < want && rd_ptr != wr_ptr) begin
                r.has_data = 1'b1;
                r.stamp    = ring_mem[rd_ptr];
                rd_ptr     = next_slot(rd_ptr);
                n++;
                r.count    = n[6:0];
                r.is_last  = (n == want) || (rd_ptr == wr_ptr);
                pending_pops.push_back(r);
            end
            if (n == 0) pending_pops.push_back(r);
        endfunction

        function void check_result(t_pop_result got);
            t_pop_result want_r;
            if (pending_pops.size() == 0) begin
                $display("%0t: result with nothing pending: sts=%0b has_data=%0b ts=%h",
                         $time, got.sts, got.has_data, got.stamp);
                $display("%0t: result with nothing pending: last=%0b dlv=%0d",
                         $time, got.is_last, got.count);
                errors++;
                return;
            end
            want_r = pending_pops.pop_front();
            if (got.sts !== want_r.sts || got.has_data !== want_r.has_data ||
                got.stamp !== want_r.stamp || got.is_last !== want_r.is_last ||
                got.count !== want_r.count) begin
                $display("%0t: expected sts=%0b has_data=%0b ts=%h last=%0b dlv=%0d", $time,
                         want_r.sts, want_r.has_data, want_r.stamp, want_r.is_last, want_r.count);
                $display("%0t: actual   sts=%0b has_data=%0b ts=%h last=%0b dlv=%0d", $time,
                         got.sts, got.has_data, got.stamp, got.is_last, got.count);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic        s_tuser  = ACT_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int snd_idle_pct = 31;
    int rcv_idle_pct = 65;
    int cycles = 0;
    capture_ring_scoreboard sb = new();

    periodic_timestamp_capture_ring_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("periodic_timestamp_capture_ring_core: mismatch");
        $finish;
    end

    // result side: check each transfer, then pick the next ready level
    initial begin
        t_pop_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                got.sts      = m_tuser[0];
                got.has_data = m_tuser[1];
                got.stamp    = m_tdata[63:0];
                got.count    = m_tdata[70:64];
                got.is_last  = m_tlast;
                sb.check_result(got);
            end
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic send_item(logic act, logic [63:0] now_ns, logic [6:0] cnt);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, cnt, now_ns};
        do @(posedge i_clk); while (!s_tready);
        sb.note_item(act, now_ns, cnt);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        // read the register back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_CAPTURE_EN: readback = {31'd0, val[0]};
            REG_MAX_STORED: readback = {25'd0, val[6:0]};
            default:        readback = val;
        endcase
        if (prdata !== readback) begin
            $display("%0t: register %0d expected %h actual %h", $time, idx, readback, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(logic en, logic [6:0] ms, logic [31:0] per);
        reg_write(REG_MAX_STORED, {25'd0, ms});
        reg_write(REG_PERIOD, per);
        reg_write(REG_CAPTURE_EN, {31'd0, en});
    endtask

    // drop valid, wait out every pending result and the tail of trailing ticks
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_pops.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    int rand_items = 0;

    task automatic run_phase(logic en, logic [6:0] ms, logic [31:0] per, int n_items,
                             int read_pct);
        logic [6:0] cnt;
        int pick;
        apply_setting(en, ms, per);
        for (int k = 0; k < n_items; k++) begin
            if (rand_items < 130) begin
                snd_idle_pct = 31;
                rcv_idle_pct = 65;
            end else if (rand_items < 260) begin
                snd_idle_pct = 65;
                rcv_idle_pct = 31;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            pick = int'($urandom_range(9));
            if (pick < 6)      cnt = 7'($urandom_range(8));
            else if (pick < 9) cnt = 7'($urandom_range(64));
            else               cnt = 7'($urandom_range(127, 65));
            if ($urandom_range(99) < read_pct)
                send_item(ACT_READ, {$urandom, $urandom}, cnt);
            else
                send_item(ACT_TICK, {$urandom, $urandom}, cnt);
            rand_items++;
        end
        settle();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // capture stopped: read refused, tick ignored
        send_item(ACT_READ, 64'd0, 7'd5);
        send_item(ACT_TICK, '1, 7'd0);
        settle();

        // small ring, capture on every tick
        apply_setting(1'b1, 7'd3, 32'd1);
        send_item(ACT_READ, 64'd0, 7'd0);
        send_item(ACT_READ, 64'd0, 7'd10);
        send_item(ACT_TICK, 64'd0, 7'd0);
        send_item(ACT_TICK, '1, 7'd127);
        send_item(ACT_TICK, 64'h5555_5555_5555_5555, 7'd0);
        send_item(ACT_TICK, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0);
        send_item(ACT_TICK, 64'd1, 7'd0);
        send_item(ACT_READ, 64'd0, 7'd127);
        send_item(ACT_TICK, 64'd2, 7'd0);
        send_item(ACT_TICK, 64'd3, 7'd0);
        send_item(ACT_READ, '1, 7'd0);
        send_item(ACT_READ, 64'd0, 7'd1);
        send_item(ACT_READ, 64'd0, 7'd64);
        settle();

        // largest ring and period: no capture within reach
        apply_setting(1'b1, 7'd127, 32'hFFFF_FFFF);
        send_item(ACT_TICK, 64'd10, 7'd0);
        send_item(ACT_TICK, 64'd11, 7'd0);
        send_item(ACT_TICK, 64'd12, 7'd0);
        send_item(ACT_READ, 64'd0, 7'd64);
        settle();

        run_phase(1'b1, 7'd127, 32'd1, 150, 8);
        run_phase(1'b1, 7'd1, 32'd1, 40, 30);
        run_phase(1'b1, 7'd7, 32'd2, 45, 25);
        run_phase(1'b1, 7'd40, 32'd3, 45, 20);
        run_phase(1'b0, 7'd20, 32'd1, 25, 40);
        run_phase(1'b1, 7'd64, 32'd5, 40, 15);
        run_phase(1'b1, 7'd2, 32'd1, 45, 35);

        if (sb.errors == 0 && sb.pending_pops.size() == 0)
            $display("periodic_timestamp_capture_ring_core: match");
        else
            $display("periodic_timestamp_capture_ring_core: mismatch");
        $finish;
    end

endmodule

### periodic_timestamp_capture_ring_core.f
rtl/ptcr_pkg.sv
rtl/periodic_timestamp_capture_ring_core.sv
tb/tb_top.sv
